/* design/fqrc_pkg.sv */
// fqrc_pkg: shared types, character codes and helpers for the FASTQ read counter.
// No dependencies; imported by every module of the block.
package fqrc_pkg;

  localparam int COUNT_BITS = 32;
  localparam int READ_COUNT_BITS = 32;

  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_NUL  = 8'h00;

  localparam logic [8:0] SCORE_NONE = 9'd256;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_END  = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ERR_HEADER = 2'd1,
    ST_WARN_AT    = 2'd2,
    ST_WARN_EXCESS = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SEQ    = 3'd1,
    PH_PLUS   = 3'd2,
    PH_QUAL   = 3'd3,
    PH_ERROR  = 3'd4
  } phase_t;

  typedef struct packed {
    command_t   command;
    logic [7:0] data_byte;
  } fqrc_in_t;

  typedef struct packed {
    status_t                    status;
    logic [READ_COUNT_BITS-1:0] read_count;
    logic [8:0]                 quality_min;
    logic [7:0]                 quality_max;
    phase_t                     parse_phase;
  } fqrc_out_t;

  typedef logic [COUNT_BITS-1:0] count_t;

  function automatic count_t sat_inc(input count_t v);
    return (&v) ? v : v + count_t'(1);
  endfunction

  function automatic logic is_terminator(input logic [7:0] b);
    return (b == CH_LF) || (b == CH_CR) || (b == CH_NUL);
  endfunction

  function automatic logic [READ_COUNT_BITS-1:0] clip_count(input count_t v);
    logic [READ_COUNT_BITS-1:0] lim;
    lim = '1;
    if (COUNT_BITS > READ_COUNT_BITS && v > count_t'(lim))
      return lim;
    return READ_COUNT_BITS'(v);
  endfunction

endpackage

/* design/fqrc_in_reg.sv */
// fqrc_in_reg: input request register in front of the parser.
// Depends on fqrc_pkg.
module fqrc_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fqrc_pkg::fqrc_in_t in_data,
  input  logic             advance,
  output logic             held_valid,
  output fqrc_pkg::fqrc_in_t held_data
);
  import fqrc_pkg::*;

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      held_data <= in_data;
    end
  end

endmodule

/* design/fqrc_parser.sv */
// fqrc_parser: parse state, one-byte step logic and result register.
// Depends on fqrc_pkg.
module fqrc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               report_quality_range,
  input  logic               held_valid,
  input  fqrc_pkg::fqrc_in_t held_data,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_ready,
  output fqrc_pkg::fqrc_out_t out_data
);
  import fqrc_pkg::*;

  phase_t     phase;
  logic       at_line_start;
  logic       line_content_done;
  logic       header_leading_cr;
  count_t     reads_seen;
  count_t     bases_in_read;
  count_t     scores_in_read;
  logic [8:0] lowest_score;
  logic [7:0] highest_score;

  phase_t     phase_next;
  logic       at_line_start_next;
  logic       line_content_done_next;
  logic       header_leading_cr_next;
  count_t     reads_seen_next;
  count_t     bases_in_read_next;
  count_t     scores_in_read_next;
  logic [8:0] lowest_score_next;
  logic [7:0] highest_score_next;
  status_t    status_next;

  assign advance = held_valid && (!out_valid || out_ready);

  always_comb begin
    logic       start;
    logic       line_end;
    logic [7:0] b;
    phase_next             = phase;
    at_line_start_next     = at_line_start;
    line_content_done_next = line_content_done;
    header_leading_cr_next = header_leading_cr;
    reads_seen_next        = reads_seen;
    bases_in_read_next     = bases_in_read;
    scores_in_read_next    = scores_in_read;
    lowest_score_next      = lowest_score;
    highest_score_next     = highest_score;
    status_next            = ST_OK;
    start                  = at_line_start;
    line_end               = 1'b0;
    b                      = held_data.data_byte;

    if (phase == PH_ERROR) begin
      status_next = ST_ERR_HEADER;
    end else if (held_data.command == CMD_DATA) begin
      at_line_start_next = 1'b0;
      line_end           = (b == CH_LF);
      case (phase)
        PH_HEADER: begin
          if (start) begin
            if (b == CH_AT) begin
              reads_seen_next        = sat_inc(reads_seen);
              bases_in_read_next     = '0;
              phase_next             = PH_SEQ;
              line_content_done_next = 1'b1;
            end else if (b == CH_CR) begin
              header_leading_cr_next = 1'b1;
            end else if (b == CH_NUL) begin
              line_content_done_next = 1'b1;
            end else if (b != CH_LF) begin
              phase_next  = PH_ERROR;
              status_next = ST_ERR_HEADER;
            end
          end else if (header_leading_cr) begin
            header_leading_cr_next = 1'b0;
            if (b == CH_NUL) begin
              line_content_done_next = 1'b1;
            end else if (b != CH_LF) begin
              phase_next  = PH_ERROR;
              status_next = ST_ERR_HEADER;
            end
          end
        end
        PH_SEQ: begin
          if (start && b == CH_PLUS) begin
            scores_in_read_next    = '0;
            phase_next             = PH_PLUS;
            line_content_done_next = 1'b1;
          end else if (!line_content_done) begin
            if (is_terminator(b)) begin
              line_content_done_next = 1'b1;
            end else begin
              bases_in_read_next = sat_inc(bases_in_read);
            end
          end
        end
        PH_PLUS, PH_QUAL: begin
          if (start) begin
            if (phase == PH_QUAL && b == CH_AT) begin
              status_next = ST_WARN_AT;
            end
            phase_next = PH_QUAL;
          end
          if (phase_next == PH_QUAL && !line_content_done) begin
            if (is_terminator(b)) begin
              line_content_done_next = 1'b1;
            end else begin
              scores_in_read_next = sat_inc(scores_in_read);
              if (report_quality_range) begin
                if (b > highest_score) begin
                  highest_score_next = b;
                end
                if ({1'b0, b} < lowest_score) begin
                  lowest_score_next = {1'b0, b};
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end else begin
      line_end = !at_line_start;
    end

    if (line_end) begin
      if (phase_next == PH_QUAL && scores_in_read_next >= bases_in_read_next) begin
        if (scores_in_read_next > bases_in_read_next) begin
          status_next = ST_WARN_EXCESS;
        end
        phase_next = PH_HEADER;
      end
      at_line_start_next     = 1'b1;
      line_content_done_next = 1'b0;
      header_leading_cr_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      at_line_start     <= 1'b1;
      line_content_done <= 1'b0;
      header_leading_cr <= 1'b0;
      reads_seen        <= '0;
      bases_in_read     <= '0;
      scores_in_read    <= '0;
      lowest_score      <= SCORE_NONE;
      highest_score     <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (advance) begin
        phase             <= phase_next;
        at_line_start     <= at_line_start_next;
        line_content_done <= line_content_done_next;
        header_leading_cr <= header_leading_cr_next;
        reads_seen        <= reads_seen_next;
        bases_in_read     <= bases_in_read_next;
        scores_in_read    <= scores_in_read_next;
        lowest_score      <= lowest_score_next;
        highest_score     <= highest_score_next;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_data.status      <= status_next;
      out_data.read_count  <= clip_count(reads_seen_next);
      out_data.quality_min <= lowest_score_next;
      out_data.quality_max <= highest_score_next;
      out_data.parse_phase <= phase_next;
    end
  end

endmodule

/* design/fastq_read_counter.sv */
// fastq_read_counter: top level of the FASTQ read counter.
// Depends on fqrc_pkg, fqrc_in_reg and fqrc_parser.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one request per byte:
//   command CMD_DATA with a text byte, or CMD_END to close an open last line.
//   Output channel (out_valid/out_ready/out_data) returns exactly one result
//   per request, in order: status, saturating read count, quality min/max
//   and the parse phase after that byte.
//   cfg_write_en/cfg_write_data set report_quality_range; write it only
//   while no request is in flight.
// Timing:
//   A request is accepted into the input register, then the parse step writes
//   its result into the result register, where it stays valid until taken.
//   Throughput is one byte per cycle while out_ready keeps taking results;
//   the combinational parse step closes the state loop.
// Reset (rst, synchronous): header phase, counters cleared, quality min 256,
//   report_quality_range set, both pipeline registers empty.
// Stall: while out_ready is low the result holds; one more request is taken
//   into the input register, then in_ready drops until the result drains.
module fastq_read_counter (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic                cfg_write_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  fqrc_pkg::fqrc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fqrc_pkg::fqrc_out_t out_data
);
  import fqrc_pkg::*;

  logic     report_quality_range;
  logic     held_valid;
  fqrc_in_t held_data;
  logic     advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_quality_range <= 1'b1;
    end else if (cfg_write_en) begin
      report_quality_range <= cfg_write_data;
    end
  end

  fqrc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  fqrc_parser u_parser (
    .clk                  (clk),
    .rst                  (rst),
    .report_quality_range (report_quality_range),
    .held_valid           (held_valid),
    .held_data            (held_data),
    .advance              (advance),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data             (out_data)
  );

endmodule

/* design/fqrc_checker.sv */
// fqrc_checker: port-level checks for fastq_read_counter, bound to the top.
// Depends on fqrc_pkg.
module fqrc_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input fqrc_pkg::fqrc_out_t out_data
);
  import fqrc_pkg::*;

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_err_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_ERR_HEADER |-> out_data.parse_phase == PH_ERROR)
    else $error("header error without error phase");

  a_phase_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.parse_phase == PH_ERROR |-> out_data.status == ST_ERR_HEADER)
    else $error("error phase without error status");

  a_excess_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_WARN_EXCESS |-> out_data.parse_phase == PH_HEADER)
    else $error("excess quality did not close the read");

endmodule

bind fastq_read_counter fqrc_checker u_fqrc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/fastq_read_counter_checker.sv */
`timescale 1ns / 100ps
// fastq_read_counter_checker: passive checker for the FASTQ read counter. Tracks the
// parse state from accepted requests and compares every result field by field.
// Depends on fqrc_pkg.
module fastq_read_counter_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic                cfg_write_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  fqrc_pkg::fqrc_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  fqrc_pkg::fqrc_out_t out_data,
  output int                  fail_count,
  output int                  outstanding
);
  import fqrc_pkg::*;

  localparam int MAX_REPORTS = 10;

  bit         track_range;
  phase_t     ph;
  bit         line_start;
  bit         content_done;
  bit         lead_cr;
  count_t     reads_total;
  count_t     bases_total;
  count_t     scores_total;
  logic [8:0] lo;
  logic [7:0] hi;
  fqrc_out_t  expected_summaries [$];

  function automatic count_t sat_bump(input count_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic bit ends_content(input logic [7:0] b);
    return b == CH_LF || b == CH_CR || b == CH_NUL;
  endfunction

  function automatic status_t finish_line();
    status_t st;
    st = ST_OK;
    if (ph == PH_QUAL && scores_total >= bases_total) begin
      if (scores_total > bases_total) st = ST_WARN_EXCESS;
      ph = PH_HEADER;
    end
    line_start   = 1'b1;
    content_done = 1'b0;
    lead_cr      = 1'b0;
    return st;
  endfunction

  task automatic advance_parser(input fqrc_in_t req, output fqrc_out_t res);
    status_t    st;
    status_t    eol;
    logic [7:0] b;
    bit         first;
    st = ST_OK;
    b  = req.data_byte;
    if (ph == PH_ERROR) begin
      st = ST_ERR_HEADER;
    end else if (req.command == CMD_END) begin
      if (!line_start) st = finish_line();
    end else begin
      first      = line_start;
      line_start = 1'b0;
      case (ph)
        PH_HEADER: begin
          if (first) begin
            if (b == CH_AT) begin
              reads_total  = sat_bump(reads_total);
              bases_total  = '0;
              ph           = PH_SEQ;
              content_done = 1'b1;
            end else if (b == CH_CR) begin
              lead_cr = 1'b1;
            end else if (b == CH_NUL) begin
              content_done = 1'b1;
            end else if (b != CH_LF) begin
              ph = PH_ERROR;
              st = ST_ERR_HEADER;
            end
          end else if (lead_cr) begin
            lead_cr = 1'b0;
            if (b == CH_NUL) begin
              content_done = 1'b1;
            end else if (b != CH_LF) begin
              ph = PH_ERROR;
              st = ST_ERR_HEADER;
            end
          end
        end
        PH_SEQ: begin
          if (first && b == CH_PLUS) begin
            scores_total = '0;
            ph           = PH_PLUS;
            content_done = 1'b1;
          end else if (!content_done) begin
            if (ends_content(b)) content_done = 1'b1;
            else bases_total = sat_bump(bases_total);
          end
        end
        PH_PLUS, PH_QUAL: begin
          if (first) begin
            if (ph == PH_QUAL && b == CH_AT) st = ST_WARN_AT;
            ph = PH_QUAL;
          end
          if (ph == PH_QUAL && !content_done) begin
            if (ends_content(b)) begin
              content_done = 1'b1;
            end else begin
              scores_total = sat_bump(scores_total);
              if (track_range) begin
                if (b > hi) hi = b;
                if (9'(b) < lo) lo = 9'(b);
              end
            end
          end
        end
        default: ;
      endcase
      if (ph != PH_ERROR && b == CH_LF) begin
        eol = finish_line();
        if (eol != ST_OK) st = eol;
      end
    end
    res.status      = st;
    res.read_count  = clip_count(reads_total);
    res.quality_min = lo;
    res.quality_max = hi;
    res.parse_phase = ph;
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    fqrc_out_t want;
    if (rst) begin
      track_range  = 1'b1;
      ph           = PH_HEADER;
      line_start   = 1'b1;
      content_done = 1'b0;
      lead_cr      = 1'b0;
      reads_total  = '0;
      bases_total  = '0;
      scores_total = '0;
      lo           = SCORE_NONE;
      hi           = '0;
      fail_count   = 0;
      expected_summaries.delete();
    end else begin
      if (cfg_write_en) track_range = cfg_write_data;
      if (in_valid && in_ready) begin
        advance_parser(in_data, want);
        expected_summaries.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_summaries.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result with no request outstanding", $time);
        end else begin
          want = expected_summaries.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("read_count", want.read_count, out_data.read_count);
          check_field("quality_min", 32'(want.quality_min), 32'(out_data.quality_min));
          check_field("quality_max", 32'(want.quality_max), 32'(out_data.quality_max));
          check_field("parse_phase", 32'(want.parse_phase), 32'(out_data.parse_phase));
        end
      end
    end
    outstanding <= expected_summaries.size();
  end

endmodule

/* tb/fastq_read_counter_tb.sv */
`timescale 1ns / 100ps
// fastq_read_counter_tb: drives FASTQ text requests into the read counter, with random
// gaps and output stalls, and reports the verdict. Depends on fqrc_pkg,
// fastq_read_counter and fastq_read_counter_checker.
module fastq_read_counter_tb;
  import fqrc_pkg::*;

  localparam int         ITEM_GOAL    = 1550;
  localparam int         PHASES       = 8;
  localparam int         LONG_HOLD    = 300;
  localparam int         DRAIN_CYCLES = 6;
  localparam int         CYCLE_LIMIT  = 500000;
  localparam logic [7:0] BAD_LEAD     = "Q";

  logic      clk            = 1'b0;
  logic      rst            = 1'b1;
  logic      cfg_write_en   = 1'b0;
  logic      cfg_write_data = 1'b0;
  logic      in_valid       = 1'b0;
  logic      in_ready;
  fqrc_in_t  in_data        = '{CMD_DATA, 8'h00};
  logic      out_valid;
  logic      out_ready      = 1'b0;
  fqrc_out_t out_data;

  int fail_count;
  int outstanding;
  int cycle_count   = 0;
  int items_sent    = 0;
  int gap_pct       = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  bit quiet         = 1'b0;

  fastq_read_counter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

  fastq_read_counter_checker summary_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : receiver
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (holds_served < hold_requests) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_served++;
      end else if (quiet || $urandom_range(0, 99) >= rx_stall_pct) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  task automatic send_request(input fqrc_in_t req);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic put_byte(input logic [7:0] b);
    fqrc_in_t req;
    req.command   = CMD_DATA;
    req.data_byte = b;
    send_request(req);
    items_sent++;
  endtask

  task automatic put_end();
    fqrc_in_t req;
    req.command   = CMD_END;
    req.data_byte = 8'($urandom_range(0, 255));
    send_request(req);
    items_sent++;
  endtask

  // end request at a line start: ignored by the block, not counted
  task automatic idle_end();
    fqrc_in_t req;
    req.command   = CMD_END;
    req.data_byte = 8'($urandom_range(0, 255));
    send_request(req);
  endtask

  task automatic drain_and_configure(input bit track);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= track;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [7:0] any_but_lf();
    logic [7:0] r;
    do r = 8'($urandom_range(0, 255)); while (r == CH_LF);
    return r;
  endfunction

  function automatic logic [7:0] score_byte();
    logic [7:0] r;
    do r = 8'($urandom_range(1, 255)); while (r == CH_LF || r == CH_CR);
    return r;
  endfunction

  function automatic logic [7:0] base_byte(input bit lead);
    logic [7:0] r;
    if ($urandom_range(0, 7) != 0) begin
      case ($urandom_range(0, 4))
        0: r = "A";
        1: r = "C";
        2: r = "G";
        3: r = "T";
        default: r = "N";
      endcase
    end else begin
      do r = 8'($urandom_range(1, 255));
      while (r == CH_LF || r == CH_CR || (lead && r == CH_PLUS));
    end
    return r;
  endfunction

  // line terminator; an end request only closes a line that holds something
  task automatic close_text_line(input bit line_open);
    int r;
    r = $urandom_range(0, 9);
    if (line_open && r == 0) begin
      put_end();
    end else if (r <= 2) begin
      put_byte(CH_CR);
      put_byte(CH_LF);
    end else begin
      put_byte(CH_LF);
    end
  endtask

  // content cut short by CR or NUL, followed by ignored junk
  task automatic maybe_cut(output bit cut);
    cut = ($urandom_range(0, 5) == 0);
    if (cut) begin
      put_byte($urandom_range(0, 1) ? CH_CR : CH_NUL);
      repeat ($urandom_range(0, 3)) put_byte(any_but_lf());
    end
  endtask

  task automatic emit_blank();
    case ($urandom_range(0, 5))
      0: put_byte(CH_LF);
      1: begin
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
      2: begin
        put_byte(CH_NUL);
        repeat ($urandom_range(0, 3)) put_byte(any_but_lf());
        close_text_line(1'b1);
      end
      3: begin
        put_byte(CH_CR);
        put_byte(CH_NUL);
        repeat ($urandom_range(0, 3)) put_byte(any_but_lf());
        close_text_line(1'b1);
      end
      4: begin
        put_byte(CH_CR);
        put_end();
      end
      default: idle_end();
    endcase
  endtask

  task automatic emit_record();
    int bases;
    int scores;
    int len;
    int qline;
    bit excess;
    bit cut;
    put_byte(CH_AT);
    repeat ($urandom_range(0, 5)) put_byte(any_but_lf());
    close_text_line(1'b1);
    bases = 0;
    repeat ($urandom_range(0, 3)) begin
      len = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) put_byte(base_byte(i == 0));
      maybe_cut(cut);
      bases += len;
      close_text_line(len > 0 || cut);
    end
    put_byte(CH_PLUS);
    repeat ($urandom_range(0, 4)) put_byte(any_but_lf());
    close_text_line(1'b1);
    excess = ($urandom_range(0, 7) == 0);
    scores = 0;
    qline  = 0;
    do begin
      len = $urandom_range(0, (bases - scores) < 6 ? bases - scores : 6);
      if (qline >= 2 && len == 0 && bases > scores) len = 1;
      if (excess && scores + len >= bases) len = bases - scores + $urandom_range(1, 3);
      for (int i = 0; i < len; i++)
        put_byte((i == 0 && $urandom_range(0, 4) == 0) ? CH_AT : score_byte());
      maybe_cut(cut);
      scores += len;
      qline++;
      close_text_line(len > 0 || cut);
    end while (scores < bases);
  endtask

  initial begin : stimulus
    int start;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    drain_and_configure(1'b1);

    gap_pct      = 20;
    rx_stall_pct = 20;
    put_byte(CH_LF);
    put_byte(CH_CR);  put_byte(CH_LF);
    put_byte(CH_NUL); put_byte("Z");     put_byte(CH_LF);
    put_byte(CH_CR);  put_byte(CH_NUL);  put_byte(CH_LF);
    put_byte(CH_CR);  put_end();
    put_byte(CH_AT);  put_byte(8'hFF);   put_byte(CH_LF);
    put_byte("A");    put_byte(CH_LF);
    put_byte("C");    put_byte(CH_LF);
    put_byte(CH_PLUS); put_byte(8'h80);  put_byte(CH_LF);
    put_byte(8'h01);  put_byte(CH_LF);
    put_byte(CH_AT);  put_byte(8'hFF);   put_end();
    idle_end();

    start = items_sent;
    for (int p = 0; p < PHASES; p++) begin
      drain_and_configure(p == 0 ? 1'b0 : p == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 25;
        default: rx_stall_pct = 60;
      endcase
      if (p == 2) begin
        gap_pct = 0;
        hold_requests++;
      end
      if (p == PHASES - 1) quiet = 1'b1;
      while (items_sent < start + (p + 1) * ITEM_GOAL / PHASES) begin
        if ($urandom_range(0, 5) == 0) emit_blank();
        emit_record();
      end
    end

    // bad header after a leading CR; the error then sticks
    put_byte(CH_CR);
    put_byte(BAD_LEAD);
    repeat (6) begin
      if ($urandom_range(0, 3) == 0) put_end();
      else put_byte(8'($urandom_range(0, 255)));
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
design/fqrc_pkg.sv
design/fqrc_in_reg.sv
design/fqrc_parser.sv
design/fastq_read_counter.sv
design/fqrc_checker.sv
tb/fastq_read_counter_checker.sv
tb/fastq_read_counter_tb.sv
